@@ design/q2e_pkg.sv @@
// Shared constants, lane types and helper functions for the quaternion to
// roll/pitch/yaw pipeline. No dependencies; imported by every module.
package q2e_pkg;

   localparam int DATA_W           = 16;
   localparam int PROD_W           = 2 * DATA_W;
   localparam int SUM_W            = 35;
   localparam int MAG_W            = 41;
   localparam int CX_W             = 44;
   localparam int ANG_W            = 33;
   localparam int SQ_W             = 58;
   localparam int SQ_TOP           = 56;
   localparam int SQRT_STEPS       = SQ_TOP / 2 + 1;
   localparam int NORM_STEPS       = 6;
   localparam int ANGLE_ITERATIONS = 16;
   localparam int FRONT_STEPS      = 5;
   localparam int BACK_STEPS       = NORM_STEPS + ANGLE_ITERATIONS;
   localparam int LAT              = FRONT_STEPS + SQRT_STEPS + 1 + BACK_STEPS;
   localparam int OUT_W            = 17;
   localparam int SQM_W            = 28;

   localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(1) <<< 28;
   localparam logic signed [OUT_W-1:0] QUARTER_POS = OUT_W'(16384);
   localparam logic signed [OUT_W-1:0] QUARTER_NEG = -OUT_W'(16384);

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sp;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic                    clamp;
   } side_type;

   typedef struct packed {
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic             xneg;
      logic             yneg;
      logic             zero;
   } nm_type;

   typedef struct packed {
      logic signed [CX_W-1:0]  cx;
      logic signed [CX_W-1:0]  cy;
      logic signed [ANG_W-1:0] z;
      logic                    xneg;
      logic                    yneg;
      logic                    zero;
   } cd_type;

   // arctan(2^-i) with 2^31 = pi
   function automatic logic signed [ANG_W-1:0] arc_tab(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return signed'({1'b0, a});
   endfunction

   function automatic logic [SQ_W-1:0] sqrt_bit(input int k);
      return SQ_W'(1) << (SQ_TOP - 2 * k);
   endfunction

   function automatic logic [5:0] norm_shift(input int k);
      return 6'(32 >> k);
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      logic signed [MAG_W-1:0] e;
      e = {{(MAG_W - SUM_W){v[SUM_W-1]}}, v};
      return v[SUM_W-1] ? -e : e;
   endfunction

   // final angle: clamp to first quadrant, unfold, round to 16 bits
   function automatic logic signed [OUT_W-1:0] angle_out(input cd_type c);
      logic [31:0]             zc;
      logic [32:0]             rs;
      logic signed [OUT_W-1:0] r;
      if (c.z < 0) begin
         zc = '0;
      end else if (c.z > (ANG_W'(1) <<< 30)) begin
         zc = 32'h4000_0000;
      end else begin
         zc = c.z[31:0];
      end
      if (c.xneg) begin
         zc = 32'h8000_0000 - zc;
      end
      rs = {1'b0, zc} + 33'd32768;
      r  = signed'(rs[32:16]);
      if (c.yneg) begin
         r = -r;
      end
      if (c.zero) begin
         r = '0;
      end
      return r;
   endfunction

endpackage

@@ design/q2e_sqrt_cell.sv @@
// One restoring square-root step (one result bit) with a carried side payload.
// Depends on q2e_pkg.
module q2e_sqrt_cell
   import q2e_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  logic [SQ_W-1:0] bit_val,
   input  sq_type          d_in,
   input  side_type        side_in,
   output sq_type          q_out,
   output side_type        side_out
);

   sq_type          q_ff, q_in;
   side_type        side_ff;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = d_in.root + bit_val;
      if (d_in.rem >= trial) begin
         q_in.rem  = d_in.rem - trial;
         q_in.root = (d_in.root >> 1) + bit_val;
      end else begin
         q_in.rem  = d_in.rem;
         q_in.root = d_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff    <= q_in;
         side_ff <= side_in;
      end
   end

   assign q_out    = q_ff;
   assign side_out = side_ff;

endmodule

@@ design/q2e_norm_cell.sv @@
// One step of the operand normalizer: shifts both magnitudes left by a
// fixed amount when that keeps them below 2^41. Depends on q2e_pkg.
module q2e_norm_cell
   import q2e_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  logic [5:0] sh,
   input  nm_type     d_in,
   output nm_type     q_out
);

   nm_type           q_ff, q_in;
   logic [MAG_W-1:0] m;
   logic [MAG_W:0]   lim;

   always_comb begin
      m    = d_in.ax | d_in.ay;
      lim  = (MAG_W + 1)'(1) << (MAG_W - int'(sh));
      q_in = d_in;
      if ((m != '0) && ({1'b0, m} < lim)) begin
         q_in.ax = d_in.ax << sh;
         q_in.ay = d_in.ay << sh;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

@@ design/q2e_cordic_cell.sv @@
// One vectoring CORDIC rotation, fixed step index per cell.
// Depends on q2e_pkg.
module q2e_cordic_cell
   import q2e_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] idx,
   input  cd_type     d_in,
   output cd_type     q_out
);

   cd_type                  q_ff, q_in;
   logic signed [CX_W-1:0]  dx, dy;
   logic signed [ANG_W-1:0] a;

   always_comb begin
      dx   = d_in.cy >>> idx;
      dy   = d_in.cx >>> idx;
      a    = arc_tab(idx);
      q_in = d_in;
      if (d_in.cy > 0) begin
         q_in.cx = d_in.cx + dx;
         q_in.cy = d_in.cy - dy;
         q_in.z  = d_in.z + a;
      end else begin
         q_in.cx = d_in.cx - dx;
         q_in.cy = d_in.cy + dy;
         q_in.z  = d_in.z - a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

@@ design/quaternion_to_euler_angles.sv @@
// Top level: unit quaternion in, roll/pitch/yaw binary angles out.
// Depends on q2e_pkg, q2e_sqrt_cell, q2e_norm_cell, q2e_cordic_cell.
//
// Usage:
//  - req channel carries one quaternion per item, w,x,y,z in signed Q1.14.
//  - rsp channel returns roll, pitch, yaw (32768 = pi) and a pitch clamp
//    flag in tuser, set when |2(wy-zx)| reached one and pitch saturated.
//  - Fully pipelined: one item per cycle while rsp is not stalled. A result
//    reaches rsp through 57 pipeline stages, the first loaded on the edge
//    that takes its item, then the output register:
//    5 front stages for the products, 29 square-root cells, 1 prep stage,
//    6 normalizer cells and 16 CORDIC cells, three angles in parallel.
//  - Stall: the whole pipe holds only when the last stage holds an item
//    and the output register is full and not taken; bubbles keep flowing
//    so new items are taken while a result waits.
//  - Reset clears all valid bits; data registers are not reset.
module quaternion_to_euler_angles
   import q2e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
   output logic [0:0]  rsp_tuser   // pitch_clamped[0]
);

   logic en;
   logic [LAT-1:0] vld_ff;

   // front end registers
   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   side_type               side1_ff, side2_ff, side3_ff, side4_ff, side1_in, side2_in;
   logic [SQM_W-1:0]       spm_ff;
   logic [2*SQM_W-1:0]     s2_ff;
   sq_type                 sq4_ff;
   logic [MAG_W-1:0]       spm_in;

   logic signed [DATA_W-1:0] qw, qx, qy, qz;

   // cell chains
   sq_type   sq_w   [0:SQRT_STEPS];
   side_type side_w [0:SQRT_STEPS];
   nm_type   nm_w   [0:2][0:NORM_STEPS];
   cd_type   cd_w   [0:2][0:ANGLE_ITERATIONS];
   nm_type   prep_in [0:2];
   logic     clamp_ff [0:BACK_STEPS];

   logic [47:0] rsp_tdata_ff;
   logic        rsp_tvalid_ff, rsp_tuser_ff;

   logic signed [OUT_W-1:0] roll_r, pitch_r, yaw_r, pitch_s;

   assign en         = !vld_ff[LAT-1] || !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   assign qw = signed'(req_tdata[15:0]);
   assign qx = signed'(req_tdata[31:16]);
   assign qy = signed'(req_tdata[47:32]);
   assign qz = signed'(req_tdata[63:48]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // stage 1: products (exact, Q.28)
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= qw * qx;
         yz_ff <= qy * qz;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         wy_ff <= qw * qy;
         zx_ff <= qz * qx;
         wz_ff <= qw * qz;
         xy_ff <= qx * qy;
         zz_ff <= qz * qz;
      end
   end

   // stage 2: the five angle terms
   always_comb begin
      side1_in.sr    = (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      side1_in.cr    = ONE_Q28 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      side1_in.sp    = (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
      side1_in.sy    = (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      side1_in.cy    = ONE_Q28 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      side1_in.clamp = 1'b0;
      spm_in         = mag_of(side1_ff.sp);
      side2_in       = side1_ff;
      side2_in.clamp = spm_in >= MAG_W'(1 << 28);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         // stage 3: |sp| and saturation test
         side2_ff <= side2_in;
         spm_ff   <= spm_in[SQM_W-1:0];
         // stage 4: sp squared
         s2_ff    <= spm_ff * spm_ff;
         side3_ff <= side2_ff;
         // stage 5: 1 - sp^2 for the root, zero when clamped
         sq4_ff   <= '{rem:  (side3_ff.clamp ? SQ_W'(0)
                                             : (SQ_W'(1) << SQ_TOP) - SQ_W'(s2_ff)),
                       root: SQ_W'(0)};
         side4_ff <= side3_ff;
      end
   end

   assign sq_w[0]   = sq4_ff;
   assign side_w[0] = side4_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      q2e_sqrt_cell u_cell (
         .clock    (clock),
         .en       (en),
         .bit_val  (sqrt_bit(k)),
         .d_in     (sq_w[k]),
         .side_in  (side_w[k]),
         .q_out    (sq_w[k+1]),
         .side_out (side_w[k+1])
      );
   end

   // prep: magnitudes and signs per lane (roll, pitch, yaw)
   function automatic nm_type lane_of(input logic signed [SUM_W-1:0] y,
                                      input logic signed [SUM_W-1:0] x);
      nm_type n;
      n.ax   = mag_of(x);
      n.ay   = mag_of(y);
      n.xneg = x < 0;
      n.yneg = y < 0;
      n.zero = (x == '0) && (y == '0);
      return n;
   endfunction

   always_comb begin
      prep_in[0] = lane_of(side_w[SQRT_STEPS].sr, side_w[SQRT_STEPS].cr);
      prep_in[1] = lane_of(side_w[SQRT_STEPS].sp,
                           signed'(sq_w[SQRT_STEPS].root[SUM_W-1:0]));
      prep_in[2] = lane_of(side_w[SQRT_STEPS].sy, side_w[SQRT_STEPS].cy);
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      nm_type prep_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            prep_ff <= prep_in[l];
         end
      end

      assign nm_w[l][0] = prep_ff;

      for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
         q2e_norm_cell u_cell (
            .clock (clock),
            .en    (en),
            .sh    (norm_shift(k)),
            .d_in  (nm_w[l][k]),
            .q_out (nm_w[l][k+1])
         );
      end

      always_comb begin
         cd_w[l][0].cx   = signed'(CX_W'(nm_w[l][NORM_STEPS].ax));
         cd_w[l][0].cy   = signed'(CX_W'(nm_w[l][NORM_STEPS].ay));
         cd_w[l][0].z    = '0;
         cd_w[l][0].xneg = nm_w[l][NORM_STEPS].xneg;
         cd_w[l][0].yneg = nm_w[l][NORM_STEPS].yneg;
         cd_w[l][0].zero = nm_w[l][NORM_STEPS].zero;
      end

      for (genvar k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
         q2e_cordic_cell u_cell (
            .clock (clock),
            .en    (en),
            .idx   (5'(k)),
            .d_in  (cd_w[l][k]),
            .q_out (cd_w[l][k+1])
         );
      end
   end

   // clamp flag rides alongside the prep, normalizer and CORDIC stages
   always_ff @(posedge clock) begin
      if (en) begin
         clamp_ff[0] <= side_w[SQRT_STEPS].clamp;
         for (int j = 0; j < BACK_STEPS; j++) begin
            clamp_ff[j+1] <= clamp_ff[j];
         end
      end
   end

   // final rounding and pitch saturation
   always_comb begin
      roll_r  = angle_out(cd_w[0][ANGLE_ITERATIONS]);
      pitch_r = angle_out(cd_w[1][ANGLE_ITERATIONS]);
      yaw_r   = angle_out(cd_w[2][ANGLE_ITERATIONS]);
      if (clamp_ff[BACK_STEPS]) begin
         pitch_s = cd_w[1][ANGLE_ITERATIONS].yneg ? QUARTER_NEG : QUARTER_POS;
      end else if (pitch_r > QUARTER_POS) begin
         pitch_s = QUARTER_POS;
      end else if (pitch_r < QUARTER_NEG) begin
         pitch_s = QUARTER_NEG;
      end else begin
         pitch_s = pitch_r;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (en && vld_ff[LAT-1]) begin
            rsp_tvalid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && vld_ff[LAT-1]) begin
         rsp_tdata_ff <= {yaw_r[15:0], pitch_s[15:0], roll_r[15:0]};
         rsp_tuser_ff <= clamp_ff[BACK_STEPS];
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

`ifndef SYNTH
   a_clamp_quarter : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[31:16] == 16'h4000 || rsp_tdata[31:16] == 16'hC000))
      else $error("clamped pitch is not a quarter turn");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:16]) <= 16'sd16384 &&
                      $signed(rsp_tdata[31:16]) >= -16'sd16384))
      else $error("pitch outside quarter turn");

   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-1] && !en |=> vld_ff[LAT-1] && rsp_tvalid)
      else $error("last stage item lost during stall");
`endif

endmodule

@@ tb/tb_top.sv @@
// Testbench for quaternion_to_euler_angles (depends on q2e_pkg): directed
// table plus random items, checked against typed or CORDIC-predicted angles.
module tb_top;
   import q2e_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   quaternion_to_euler_angles dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
      logic        clamped;
   } angles_type;

   // directed row: quaternion, typed expectation when known
   typedef struct {
      logic [15:0] w, x, y, z;
      bit          known;
      angles_type  ang;
   } row_type;

   angles_type  angles_q[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_got = 0;
   int          n_clamped = 0;
   bit          quiet = 1'b0;     // no idling on either side
   bit          stim_done = 1'b0;

   localparam longint ONE28 = longint'(1) << 28;
   localparam longint ATAN_STEP [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // vectoring CORDIC atan2, 16-bit binary angle
   function automatic longint cordic_atan2(longint y, longint x);
      longint ax, ay, cx, cy, ang, dx, dy, r;
      ax = abs64(x);
      ay = abs64(y);
      ang = 0;
      if (ax == 0 && ay == 0) return 0;
      while ((ax | ay) < (longint'(1) << 40)) begin
         ax <<= 1;
         ay <<= 1;
      end
      cx = ax;
      cy = ay;
      for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx; cy -= dy; ang += ATAN_STEP[i];
         end else begin
            cx -= dx; cy += dy; ang -= ATAN_STEP[i];
         end
      end
      if (ang < 0) ang = 0;
      if (ang > (longint'(1) << 30)) ang = longint'(1) << 30;
      if (x < 0) ang = (longint'(1) << 31) - ang;
      r = (ang + 32768) >>> 16;
      return y < 0 ? -r : r;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res, b;
      res = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_of(logic [63:0] q);
      longint w, x, y, z, sp, p;
      angles_type a;
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      a.roll = 16'(cordic_atan2(2 * (w * x + y * z), ONE28 - 2 * (x * x + y * y)));
      a.yaw  = 16'(cordic_atan2(2 * (w * z + x * y), ONE28 - 2 * (y * y + z * z)));
      sp = 2 * (w * y - z * x);
      if (abs64(sp) >= ONE28) begin
         // gimbal lock: pitch saturates to a quarter turn
         p = sp < 0 ? -16384 : 16384;
         a.clamped = 1'b1;
      end else begin
         p = cordic_atan2(sp, int_sqrt((longint'(1) << 56) - sp * sp));
         if (p > 16384) p = 16384;
         if (p < -16384) p = -16384;
         a.clamped = 1'b0;
      end
      a.pitch = 16'(p);
      return a;
   endfunction

   // send one item; random idle bursts unless in the quiet tail
   task automatic send_quat(logic [63:0] q, bit known, angles_type ang);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angles_q.push_back(known ? ang : euler_of(q));
      n_sent++;
   endtask

   // random unit-ish quaternion, gimbal lock case, or raw noise
   function automatic logic [63:0] rand_quat();
      real a, b, c, d, n;
      int  k;
      k = $urandom_range(0, 9);
      if (k < 2) return {$urandom, $urandom};
      if (k == 2) begin
         // gimbal lock region: w = y or w = -y, x = z = 0, scaled near one
         a = 11585.0 + $urandom_range(0, 40) - 20.0;
         return {16'(0), 16'(($urandom_range(0, 1) ? 1 : -1) * int'(a)),
                 16'(0), 16'(int'(a))};
      end
      a = $urandom_range(0, 2000) - 1000.0;
      b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0;
      d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) return '0;
      n = 16384.0 / n;
      return {16'(int'(d * n)), 16'(int'(c * n)), 16'(int'(b * n)), 16'(int'(a * n))};
   endfunction

   row_type table_rows[$];

   task automatic add_row(int w, int x, int y, int z, bit known, angles_type a);
      row_type r;
      r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
      r.known = known;
      r.ang = a;
      table_rows.push_back(r);
   endtask

   // stimulus
   initial begin
      angles_type none;
      none = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // identity, and the zero quaternion: all angles zero
      add_row(16384, 0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 1'b0});
      add_row(0, 0, 0, 0, 1, '{16'd0, 16'd0, 16'd0, 1'b0});
      // pi about x: roll of pi reads back as -32768
      add_row(0, 16384, 0, 0, 1, '{16'h8000, 16'd0, 16'd0, 1'b0});
      add_row(0, 0, 0, 16384, 1, '{16'd0, 16'd0, 16'h8000, 1'b0});
      // field extremes; the first three put pitch far past one, clamped
      add_row(-32768, 0, -32768, 0, 0, none);
      add_row(32767, 0, 32767, 0, 0, none);
      add_row(32767, 0, -32768, 0, 0, none);
      add_row(-32768, -32768, -32768, -32768, 0, none);
      add_row(32767, 32767, 32767, 32767, 0, none);
      add_row(32767, -32768, 32767, -32768, 0, none);
      add_row(-1, -1, -1, -1, 0, none);
      // pitch at +-one: |2(wy-zx)| >= 2^28; cr = cy = -1 in the w=8192 rows
      add_row(11585, 0, 11586, 0, 0, none);
      add_row(8192, 0, 16384, 0, 1, '{16'h8000, 16'd16384, 16'h8000, 1'b1});
      add_row(8192, 0, -16384, 0, 1, '{16'h8000, 16'hC000, 16'h8000, 1'b1});
      add_row(0, 8192, 0, 16384, 0, none);
      // plain rotations
      add_row(11585, 11585, 0, 0, 0, none);
      add_row(11585, 0, 11585, 0, 0, none);
      add_row(11585, 0, 0, -11585, 0, none);
      add_row(8192, 8192, 8192, 8192, 0, none);
      add_row(8192, -8192, 8192, -8192, 0, none);
      foreach (table_rows[i])
         send_quat({table_rows[i].z, table_rows[i].y, table_rows[i].x, table_rows[i].w},
                   table_rows[i].known, table_rows[i].ang);
      for (int i = 0; i < 1850; i++) begin
         if (i == 1600) quiet = 1'b1;
         send_quat(rand_quat(), 1'b0, none);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // result sink with random stalls
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            angles_type got;
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser[0]};
            n_got++;
            if (angles_q.size() == 0) begin
               $error("result with nothing expected: %h", got);
               errors++;
            end else begin
               angles_type exp_a;
               exp_a = angles_q.pop_front();
               if (got.roll !== exp_a.roll) begin
                  $error("roll_angle expected %h got %h", exp_a.roll, got.roll);
                  errors++;
               end
               if (got.pitch !== exp_a.pitch) begin
                  $error("pitch_angle expected %h got %h", exp_a.pitch, got.pitch);
                  errors++;
               end
               if (got.yaw !== exp_a.yaw) begin
                  $error("yaw_angle expected %h got %h", exp_a.yaw, got.yaw);
                  errors++;
               end
               if (got.clamped !== exp_a.clamped) begin
                  $error("pitch_clamped expected %b got %b", exp_a.clamped, got.clamped);
                  errors++;
               end
               if (got.clamped === 1'b1) n_clamped++;
            end
         end
         // stall bursts; ready held low across the burst
         if (hold > 0) begin
            hold--;
            rsp_tready <= (hold == 0);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // end of run: drain the expected queue, let the pipe settle, then report
   initial begin
      wait (stim_done);
      while (angles_q.size() != 0) @(posedge clock);
      repeat (LAT + 20) @(posedge clock);
      $display("covered %0d quaternions, %0d results, %0d with pitch clamped",
               n_sent, n_got, n_clamped);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
